[rtl/wpwe_pkg.sv]
// Shared types, constants and helpers for the windowed pixel write engine.
// No dependencies; every other file in rtl imports this package.
package wpwe_pkg;

	localparam int FRAME_WIDTH  = 320;
	localparam int FRAME_HEIGHT = 240;
	localparam int STORE_SIZE   = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int ADDR_W       = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

	// Coordinates are 9 bits, so the row-major index can reach 511*width+511.
	localparam int COORD_W = 9;
	localparam int IDX_MAX = 511 * FRAME_WIDTH + 511;
	localparam int IDX_W   = $clog2(IDX_MAX + 1);

	localparam int COLOR_W = 16;

	// Command queue between the front and the back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		MODE_SET_WINDOW = 2'd0,
		MODE_WRITE      = 2'd1,
		MODE_READ       = 2'd2,
		MODE_NONE       = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		OP_NOP   = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef struct packed {
		op_t                op;
		logic               oor;
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] color;
	} cmd_t;

	// Row-major index of a coordinate pair.
	function automatic logic [IDX_W-1:0] pixel_index(
		input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y
	);
		pixel_index = IDX_W'(y) * IDX_W'(FRAME_WIDTH) + IDX_W'(x);
	endfunction

	// The store keeps RGB565; widening to 8 bits per component is a shift.
	function automatic logic [7:0] red_of(input logic [COLOR_W-1:0] c);
		red_of = {c[15:11], 3'b000};
	endfunction

	function automatic logic [7:0] green_of(input logic [COLOR_W-1:0] c);
		green_of = {c[10:5], 2'b00};
	endfunction

	function automatic logic [7:0] blue_of(input logic [COLOR_W-1:0] c);
		blue_of = {c[4:0], 3'b000};
	endfunction

endpackage

[rtl/wpwe_front.sv]
// Front end: takes requests, keeps the window and cursor, and turns each
// request into a store command. Depends on wpwe_pkg.
module wpwe_front
	import wpwe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [1:0]         mode,
	input  logic [COORD_W-1:0] x_first,
	input  logic [COORD_W-1:0] y_first,
	input  logic [COORD_W-1:0] x_last,
	input  logic [COORD_W-1:0] y_last,
	input  logic [COLOR_W-1:0] color565,
	output cmd_t               cmd
);

	logic [COORD_W-1:0] cur_x_q, cur_y_q;
	logic [COORD_W-1:0] win_xs_q, win_ys_q, win_xe_q, win_ye_q;

	logic [COORD_W:0]   nx, ny;
	logic [IDX_W-1:0]   idx;
	logic               is_write;

	always_comb begin
		nx = {1'b0, cur_x_q} + 1'b1;
		ny = {1'b0, cur_y_q};
		if (nx > {1'b0, win_xe_q}) begin
			nx = {1'b0, win_xs_q};
			ny = {1'b0, cur_y_q} + 1'b1;
		end
		if (ny > {1'b0, win_ye_q}) begin
			ny = {1'b0, win_ys_q};
		end
	end

	always_comb begin
		is_write = (mode_t'(mode) == MODE_WRITE);
		idx = is_write ? pixel_index(cur_x_q, cur_y_q) : pixel_index(x_first, y_first);
		cmd.addr  = idx[ADDR_W-1:0];
		cmd.color = color565;
		case (mode_t'(mode))
			MODE_WRITE: begin
				cmd.op  = OP_WRITE;
				cmd.oor = (idx >= IDX_W'(STORE_SIZE));
			end
			MODE_READ: begin
				cmd.op  = OP_READ;
				cmd.oor = (idx >= IDX_W'(STORE_SIZE));
			end
			default: begin
				cmd.op  = OP_NOP;
				cmd.oor = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			win_xs_q <= '0;
			win_ys_q <= '0;
			win_xe_q <= '0;
			win_ye_q <= '0;
		end else if (accept) begin
			case (mode_t'(mode))
				MODE_SET_WINDOW: begin
					win_xs_q <= x_first;
					win_ys_q <= y_first;
					win_xe_q <= x_last;
					win_ye_q <= y_last;
					cur_x_q  <= x_first;
					cur_y_q  <= y_first;
				end
				MODE_WRITE: begin
					cur_x_q <= nx[COORD_W-1:0];
					cur_y_q <= ny[COORD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/wpwe_queue.sv]
// Short command queue that decouples the front end from the store.
// Depends on wpwe_pkg.
module wpwe_queue
	import wpwe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head_cmd,
	output logic empty,
	output logic full
);

	cmd_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == QCNT_W'(QDEPTH));
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/wpwe_back.sv]
// Back end: owns the frame store, clears it after reset, carries out queued
// commands and holds the result register. Depends on wpwe_pkg.
module wpwe_back
	import wpwe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  logic       q_empty,
	output logic       pop,
	output logic       clear_busy,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic       out_of_range
);

	// Pixels are stored as RGB565; the widened low bits are always zero.
	logic [COLOR_W-1:0] store [STORE_SIZE];

	logic               clr_busy_q;
	logic [ADDR_W-1:0]  clr_addr_q;
	logic               out_valid_q, out_read_q, out_oor_q;
	logic [COLOR_W-1:0] rd_q;

	logic               take;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [COLOR_W-1:0] mem_wdata;
	logic               rd_en;
	logic               show;

	assign clear_busy = clr_busy_q;
	assign take       = out_valid_q && !out_stall;
	assign pop        = !q_empty && !clr_busy_q && (!out_valid_q || take);

	always_comb begin
		if (clr_busy_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = pop && (cmd.op == OP_WRITE) && !cmd.oor;
			mem_waddr = cmd.addr;
			mem_wdata = cmd.color;
		end
		rd_en = pop && (cmd.op == OP_READ) && !cmd.oor;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_q <= store[cmd.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == ADDR_W'(STORE_SIZE - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_read_q  <= 1'b0;
			out_oor_q   <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
			out_read_q  <= (cmd.op == OP_READ) && !cmd.oor;
			out_oor_q   <= cmd.oor;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	assign show         = out_read_q;
	assign out_valid    = out_valid_q;
	assign out_of_range = out_oor_q;
	assign red          = show ? red_of(rd_q) : 8'd0;
	assign green        = show ? green_of(rd_q) : 8'd0;
	assign blue         = show ? blue_of(rd_q) : 8'd0;

endmodule

[rtl/window_pixel_write_engine_core.sv]
// Windowed pixel write engine: RGB565 writes through an address window into
// a frame store, with pixel readback. Depends on wpwe_pkg and the wpwe modules.
//
// Usage: while in_stall is low, the block takes one request per cycle and
// returns one result per request, in order. Each request passes through the
// queue entry and the back end's result register. The single-port access to
// the frame store in the back end sets the one-per-cycle figure. After reset
// the block clears all FRAME_WIDTH*FRAME_HEIGHT pixels of the frame store
// (76800 at 320x240) to black, one pixel per cycle, and holds in_stall high
// until that pass is done. A four-entry queue lets the front end keep taking
// requests while results are stalled.
module window_pixel_write_engine_core
	import wpwe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic [COORD_W-1:0] x_first,
	input  logic [COORD_W-1:0] y_first,
	input  logic [COORD_W-1:0] x_last,
	input  logic [COORD_W-1:0] y_last,
	input  logic [COLOR_W-1:0] color565,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic               out_of_range
);

	cmd_t front_cmd, head_cmd;
	logic accept, q_empty, q_full, pop, clear_busy;

	assign in_stall = clear_busy || q_full;
	assign accept   = in_valid && !in_stall;

	wpwe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.mode     (mode),
		.x_first  (x_first),
		.y_first  (y_first),
		.x_last   (x_last),
		.y_last   (y_last),
		.color565 (color565),
		.cmd      (front_cmd)
	);

	wpwe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_cmd (front_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.empty    (q_empty),
		.full     (q_full)
	);

	wpwe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (head_cmd),
		.q_empty      (q_empty),
		.pop          (pop),
		.clear_busy   (clear_busy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.out_of_range (out_of_range)
	);

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for window_pixel_write_engine_core: a queue-fed driver, a shadow
// frame store with its own window cursor that predicts every result, and an in-order monitor.
// Depends on wpwe_pkg and the RTL of the block.
module testbench
	import wpwe_pkg::*;
();

	typedef struct packed {
		mode_t              mode;
		logic [COORD_W-1:0] xf;
		logic [COORD_W-1:0] yf;
		logic [COORD_W-1:0] xl;
		logic [COORD_W-1:0] yl;
		logic [COLOR_W-1:0] color;
	} pixel_req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       oor;
	} pixel_result_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         mode     = '0;
	logic [COORD_W-1:0] x_first  = '0;
	logic [COORD_W-1:0] y_first  = '0;
	logic [COORD_W-1:0] x_last   = '0;
	logic [COORD_W-1:0] y_last   = '0;
	logic [COLOR_W-1:0] color565 = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic               out_of_range;

	window_pixel_write_engine_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .x_first(x_first), .y_first(y_first),
		.x_last(x_last), .y_last(y_last), .color565(color565),
		.out_valid(out_valid), .out_stall(out_stall),
		.red(red), .green(green), .blue(blue), .out_of_range(out_of_range)
	);

	pixel_req_t    req_queue[$];
	pixel_req_t    offered = '0;
	pixel_result_t pixels_due[$];

	// Shadow copy of the block's state.
	logic [23:0]        shadow_store [STORE_SIZE];
	logic [COORD_W-1:0] cur_x, cur_y, win_xs, win_ys, win_xe, win_ye;

	int errors      = 0;
	int taken_count = 0;
	int in_gap      = 0;
	int stall_left  = 0;
	int hold_left   = 0;
	bit hold_done   = 1'b0;
	bit in_taken    = 1'b0;

	initial forever #6 clk = ~clk;

	initial begin
		#6_000_000;
		$display("FAILURE");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		errors++;
	endtask

	task automatic queue_req(input mode_t m, input int xf, input int yf, input int xl,
			input int yl, input int col);
		pixel_req_t r;
		r.mode  = m;
		r.xf    = COORD_W'(xf);
		r.yf    = COORD_W'(yf);
		r.xl    = COORD_W'(xl);
		r.yl    = COORD_W'(yl);
		r.color = COLOR_W'(col);
		req_queue.push_back(r);
	endtask

	// Applies one request to the shadow state and queues the pixel result it must give.
	task automatic predict_pixel(input pixel_req_t r);
		pixel_result_t res;
		int unsigned   idx;
		logic [9:0]    nx, ny;
		res = '0;
		case (r.mode)
			MODE_SET_WINDOW: begin
				win_xs = r.xf;
				win_ys = r.yf;
				win_xe = r.xl;
				win_ye = r.yl;
				cur_x  = r.xf;
				cur_y  = r.yf;
			end
			MODE_WRITE: begin
				idx = cur_y * FRAME_WIDTH + cur_x;
				if (idx < STORE_SIZE)
					shadow_store[idx] = {r.color[15:11], 3'b000, r.color[10:5], 2'b00,
						r.color[4:0], 3'b000};
				else
					res.oor = 1'b1;
				// The step is made at ten bits, so column or row 512 is past any end.
				nx = {1'b0, cur_x} + 10'd1;
				ny = {1'b0, cur_y};
				if (nx > {1'b0, win_xe}) begin
					nx = {1'b0, win_xs};
					ny = ny + 10'd1;
				end
				if (ny > {1'b0, win_ye})
					ny = {1'b0, win_ys};
				cur_x = nx[COORD_W-1:0];
				cur_y = ny[COORD_W-1:0];
			end
			MODE_READ: begin
				idx = r.yf * FRAME_WIDTH + r.xf;
				if (idx < STORE_SIZE)
					{res.red, res.green, res.blue} = shadow_store[idx];
				else
					res.oor = 1'b1;
			end
			default: ;
		endcase
		pixels_due.push_back(res);
	endtask

	// Request side: a new request is put up once the previous one was taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (req_queue.size() > 0) begin
				offered = req_queue.pop_front();
				in_valid <= 1'b1;
				mode     <= offered.mode;
				x_first  <= offered.xf;
				y_first  <= offered.yf;
				x_last   <= offered.xl;
				y_last   <= offered.yl;
				color565 <= offered.color;
				if (req_queue.size() >= 150 && hold_left == 0 && $urandom_range(7) == 0)
					in_gap = $urandom_range(1, 15);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result side stalls: short random bursts, and one long hold-off that backs the block up.
	always @(negedge clk) begin
		if (!hold_done && taken_count >= 300) begin
			hold_done = 1'b1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (req_queue.size() >= 150 && $urandom_range(7) == 0) begin
			stall_left = $urandom_range(0, 14);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : monitor
		pixel_result_t due;
		if (arst_n && in_valid && !in_stall) begin
			predict_pixel(offered);
			taken_count++;
			in_taken <= 1'b1;
		end else begin
			in_taken <= 1'b0;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pixels_due.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				due = pixels_due.pop_front();
				if (red !== due.red)
					report_mismatch($sformatf("red %h, expected %h", red, due.red));
				if (green !== due.green)
					report_mismatch($sformatf("green %h, expected %h", green, due.green));
				if (blue !== due.blue)
					report_mismatch($sformatf("blue %h, expected %h", blue, due.blue));
				if (out_of_range !== due.oor)
					report_mismatch($sformatf("out_of_range %b, expected %b",
						out_of_range, due.oor));
			end
		end
	end

	initial begin : run
		int w, h, xs, ys;
		for (int i = 0; i < STORE_SIZE; i++)
			shadow_store[i] = '0;
		cur_x  = '0;
		cur_y  = '0;
		win_xs = '0;
		win_ys = '0;
		win_xe = '0;
		win_ye = '0;

		// Reads of the cleared store at both corners and just past its last pixel.
		queue_req(MODE_READ, 0, 0, 0, 0, 0);
		queue_req(MODE_READ, 319, 239, 0, 0, 0);
		queue_req(MODE_READ, 320, 239, 0, 0, 0);
		queue_req(MODE_READ, 511, 511, 511, 511, 16'hFFFF);
		queue_req(MODE_NONE, 511, 511, 511, 511, 16'hFFFF);
		// A 2x2 window; the fifth write wraps back to the start corner.
		queue_req(MODE_SET_WINDOW, 0, 0, 1, 1, 0);
		queue_req(MODE_WRITE, 511, 511, 511, 511, 16'hFFFF);
		queue_req(MODE_WRITE, 0, 0, 0, 0, 16'h0000);
		queue_req(MODE_WRITE, 0, 0, 0, 0, 16'hF800);
		queue_req(MODE_WRITE, 0, 0, 0, 0, 16'h07E0);
		queue_req(MODE_WRITE, 0, 0, 0, 0, 16'h001F);
		queue_req(MODE_READ, 0, 0, 0, 0, 0);
		queue_req(MODE_READ, 1, 0, 0, 0, 0);
		queue_req(MODE_READ, 0, 1, 0, 0, 0);
		// The cursor runs past the frame width; column 320 of row 0 lands on row 1.
		queue_req(MODE_SET_WINDOW, 318, 0, 511, 0, 0);
		queue_req(MODE_WRITE, 0, 0, 0, 0, 16'hAAAA);
		queue_req(MODE_WRITE, 0, 0, 0, 0, 16'h5555);
		queue_req(MODE_WRITE, 0, 0, 0, 0, 16'h1234);
		queue_req(MODE_READ, 0, 1, 0, 0, 0);
		// Writes outside the store, with the cursor stepping over 511 in both axes.
		queue_req(MODE_SET_WINDOW, 510, 511, 511, 511, 0);
		queue_req(MODE_WRITE, 0, 0, 0, 0, 16'hFFFF);
		queue_req(MODE_WRITE, 0, 0, 0, 0, 16'hFFFF);
		queue_req(MODE_WRITE, 0, 0, 0, 0, 16'hFFFF);
		// Start corner beyond the end corner.
		queue_req(MODE_SET_WINDOW, 10, 10, 5, 5, 0);
		queue_req(MODE_WRITE, 0, 0, 0, 0, 16'hC3A5);
		queue_req(MODE_WRITE, 0, 0, 0, 0, 16'h3C5A);
		queue_req(MODE_READ, 10, 10, 0, 0, 0);

		// Mostly window, write burst, readback groups; the rest is unshaped noise.
		while (req_queue.size() < 1327) begin
			if ($urandom_range(99) < 80) begin
				w = $urandom_range(1, 12);
				h = $urandom_range(1, 6);
				if ($urandom_range(4) == 0) begin
					xs = $urandom_range(0, 511);
					ys = $urandom_range(0, 511);
				end else begin
					xs = $urandom_range(0, FRAME_WIDTH - w);
					ys = $urandom_range(0, FRAME_HEIGHT - h);
				end
				queue_req(MODE_SET_WINDOW, xs, ys, xs + w - 1, ys + h - 1,
					$urandom_range(0, 65535));
				repeat ($urandom_range(1, 2 * w * h))
					queue_req(MODE_WRITE, $urandom_range(0, 511), $urandom_range(0, 511),
						$urandom_range(0, 511), $urandom_range(0, 511),
						$urandom_range(0, 65535));
				repeat ($urandom_range(1, 6))
					queue_req(MODE_READ, xs + $urandom_range(0, w - 1),
						ys + $urandom_range(0, h - 1), $urandom_range(0, 511),
						$urandom_range(0, 511), $urandom_range(0, 65535));
			end else begin
				queue_req(mode_t'($urandom_range(0, 3)), $urandom_range(0, 511),
					$urandom_range(0, 511), $urandom_range(0, 511),
					$urandom_range(0, 511), $urandom_range(0, 65535));
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (req_queue.size() > 0 || in_valid || pixels_due.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
